>>> src/s3mped_pkg.sv
package s3mped_pkg;

  localparam int NoteLimit      = 96;
  localparam int RowsPerPattern = 64;
  localparam int OutDataW       = 56;

  typedef enum logic [2:0] {
    PH_LEN0  = 3'd0,
    PH_LEN1  = 3'd1,
    PH_FLAG  = 3'd2,
    PH_NOTE  = 3'd3,
    PH_INSTR = 3'd4,
    PH_VOL   = 3'd5,
    PH_CMD   = 3'd6,
    PH_INFO  = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_SPEED      = 4'd1,
    CMD_FASTSKIP   = 4'd2,
    CMD_SKIP       = 4'd3,
    CMD_SLIDEVOL   = 4'd4,
    CMD_EXTENDED   = 4'd5,
    CMD_UPSLIDE    = 4'd6,
    CMD_DOWNSLIDE  = 4'd7,
    CMD_PORTA      = 4'd8,
    CMD_VIBRATO    = 4'd9,
    CMD_ARPEGGIO   = 4'd10,
    CMD_VIBSLIDE   = 4'd11,
    CMD_PORTASLIDE = 4'd12,
    CMD_OFFSET     = 4'd13
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] arg;
  } effect_t;

  // phase that follows done, PH_FLAG when the event is complete
  function automatic phase_t next_phase(input phase_t done, input logic [7:0] flags);
    phase_t nxt;
    if (done < PH_INSTR && flags[5]) begin
      nxt = PH_NOTE;
    end else if (done < PH_VOL && flags[6]) begin
      nxt = PH_VOL;
    end else if (done < PH_CMD && flags[7]) begin
      nxt = PH_CMD;
    end else begin
      nxt = PH_FLAG;
    end
    return nxt;
  endfunction

endpackage

>>> src/s3mped_fx_map.sv
module s3mped_fx_map
  import s3mped_pkg::*;
(
  input  logic [7:0] effect_byte,
  input  logic [7:0] info,
  output effect_t    fx
);

  localparam logic [7:0] FxA = 8'd1;
  localparam logic [7:0] FxB = 8'd2;
  localparam logic [7:0] FxC = 8'd3;
  localparam logic [7:0] FxD = 8'd4;
  localparam logic [7:0] FxE = 8'd5;
  localparam logic [7:0] FxF = 8'd6;
  localparam logic [7:0] FxG = 8'd7;
  localparam logic [7:0] FxH = 8'd8;
  localparam logic [7:0] FxJ = 8'd10;
  localparam logic [7:0] FxK = 8'd11;
  localparam logic [7:0] FxL = 8'd12;
  localparam logic [7:0] FxO = 8'd15;
  localparam logic [7:0] FxS = 8'd19;
  localparam logic [7:0] FxT = 8'd20;

  logic [3:0] lo;
  logic [3:0] hi;

  assign lo = info[3:0];
  assign hi = info[7:4];

  always_comb begin
    fx.cmd = CMD_NONE;
    fx.arg = 8'd0;
    case (effect_byte)
      FxA, FxT: begin
        fx.cmd = CMD_SPEED;
        fx.arg = info;
      end
      FxB: begin
        fx.cmd = CMD_FASTSKIP;
        fx.arg = info;
      end
      FxC: begin
        fx.cmd = CMD_SKIP;
        fx.arg = info;
      end
      FxD: begin
        if (lo == 4'h0 || hi == 4'h0) begin
          fx.cmd = CMD_SLIDEVOL;
          fx.arg = info;
        end else if (hi == 4'hF) begin
          fx.cmd = CMD_EXTENDED;
          fx.arg = {4'hB, lo};
        end else if (lo == 4'hF) begin
          fx.cmd = CMD_EXTENDED;
          fx.arg = {4'hA, hi};
        end
      end
      FxE: begin
        if (hi == 4'hF) begin
          fx.cmd = CMD_EXTENDED;
          fx.arg = {4'h2, lo};
        end else if (hi != 4'hE) begin
          fx.cmd = CMD_UPSLIDE;
          fx.arg = info;
        end
      end
      FxF: begin
        if (hi == 4'hF) begin
          fx.cmd = CMD_EXTENDED;
          fx.arg = {4'h1, lo};
        end else if (hi != 4'hE) begin
          fx.cmd = CMD_DOWNSLIDE;
          fx.arg = info;
        end
      end
      FxG: begin
        fx.cmd = CMD_PORTA;
        fx.arg = info;
      end
      FxH: begin
        fx.cmd = CMD_VIBRATO;
        fx.arg = info;
      end
      FxJ: begin
        fx.cmd = CMD_ARPEGGIO;
        fx.arg = info;
      end
      FxK: begin
        fx.cmd = CMD_VIBSLIDE;
        fx.arg = info;
      end
      FxL: begin
        fx.cmd = CMD_PORTASLIDE;
        fx.arg = info;
      end
      FxO: begin
        fx.cmd = CMD_OFFSET;
        fx.arg = info;
      end
      FxS: begin
        // special commands, only some sub-effects are supported
        case (hi)
          4'h2: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'h5, lo};
          end
          4'h3: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'h4, lo};
          end
          4'h4: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'h7, lo};
          end
          4'hB: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'h6, lo};
          end
          4'hC: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'hC, lo};
          end
          4'hD: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'hD, lo};
          end
          4'hE: begin
            fx.cmd = CMD_EXTENDED;
            fx.arg = {4'hE, lo};
          end
          default: begin
            fx.cmd = CMD_NONE;
            fx.arg = 8'd0;
          end
        endcase
      end
      default: begin
        fx.cmd = CMD_NONE;
        fx.arg = 8'd0;
      end
    endcase
  end

endmodule

>>> src/s3m_pattern_event_decoder_top.sv
// channel  dir  signals                          carries
// s_       in   s_tvalid s_tready s_tdata[7:0]    data_byte
// m_       out  m_tvalid m_tready m_tdata[55:0]   event fields
//                        m_tuser                   is_pattern_end
// cfg_     in   cfg_valid cfg_ready cfg_data[5:0] num_channels
//
// one byte per clock while nothing stalls; a byte is held in the input register,
// the parse state and result are settled from it and land in the output
// register, so a result passes the input register and then the output register.
// reset (rst, synchronous) waits for the first length byte of a pattern.
// a byte that yields a result waits in the input register only while the
// output register is full and not taken; other bytes never stall.
module s3m_pattern_event_decoder_top
  import s3mped_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // data_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  // row[5:0] channel[10:6] has_note[11] note[19:12] instrument[27:20]
  // volume[35:28] has_effect[36] effect_cmd[40:37] effect_arg[48:41], zero pad
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tuser,   // is_pattern_end
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data   // num_channels
);

  logic [5:0] num_channels;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parse state
  phase_t     phase, phase_next;
  logic [5:0] row_count, row_count_next;
  logic [7:0] flag_bits, flag_bits_next;
  logic [7:0] held_note, held_note_next;
  logic [7:0] held_instrument, held_instrument_next;
  logic [7:0] held_volume, held_volume_next;
  logic [7:0] held_effect_byte, held_effect_byte_next;

  logic       emit_event;
  logic       emit_end;
  logic       emit;
  logic       advance;
  logic [7:0] note_val;
  logic [6:0] row_inc;
  logic [7:0] flag_sel;
  logic [7:0] info_sel;
  logic       ch_ok;
  logic       has_fx;
  effect_t    fx;

  logic [OutDataW-1:0] res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= 6'd32;
    end else if (cfg_valid) begin
      num_channels <= cfg_data;
    end
  end

  assign advance  = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  assign note_val = ({4'd0, in_byte[7:4]} * 8'd12) + {4'd0, in_byte[3:0]};
  assign row_inc  = {1'b0, row_count} + 7'd1;

  // next state
  always_comb begin
    phase_next            = phase;
    row_count_next        = row_count;
    flag_bits_next        = flag_bits;
    held_note_next        = held_note;
    held_instrument_next  = held_instrument;
    held_volume_next      = held_volume;
    held_effect_byte_next = held_effect_byte;
    emit_event            = 1'b0;
    emit_end              = 1'b0;
    case (phase)
      PH_LEN0: phase_next = PH_LEN1;
      PH_LEN1: phase_next = PH_FLAG;
      PH_FLAG: begin
        if (in_byte == 8'd0) begin
          if (row_inc >= 7'(RowsPerPattern)) begin
            row_count_next = 6'd0;
            phase_next     = PH_LEN0;
            emit_end       = 1'b1;
          end else begin
            row_count_next = row_inc[5:0];
          end
        end else begin
          flag_bits_next = in_byte;
          phase_next     = next_phase(PH_FLAG, in_byte);
          emit_event     = (phase_next == PH_FLAG);
        end
      end
      PH_NOTE: begin
        held_note_next = (note_val >= 8'(NoteLimit)) ? 8'hFF : note_val;
        phase_next     = PH_INSTR;
      end
      PH_INSTR: begin
        held_instrument_next = in_byte;
        phase_next           = next_phase(PH_INSTR, flag_bits);
        emit_event           = (phase_next == PH_FLAG);
      end
      PH_VOL: begin
        held_volume_next = ((in_byte > 8'h40) ? 8'h40 : in_byte) + 8'h10;
        phase_next       = next_phase(PH_VOL, flag_bits);
        emit_event       = (phase_next == PH_FLAG);
      end
      PH_CMD: begin
        held_effect_byte_next = in_byte;
        phase_next            = PH_INFO;
      end
      PH_INFO: begin
        phase_next = PH_FLAG;
        emit_event = 1'b1;
      end
      default: phase_next = PH_LEN0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN0;
      row_count        <= 6'd0;
      flag_bits        <= 8'd0;
      held_note        <= 8'd0;
      held_instrument  <= 8'd0;
      held_volume      <= 8'd0;
      held_effect_byte <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      row_count        <= row_count_next;
      flag_bits        <= flag_bits_next;
      held_note        <= held_note_next;
      held_instrument  <= held_instrument_next;
      held_volume      <= held_volume_next;
      held_effect_byte <= held_effect_byte_next;
    end
  end

  // event fields, built from the state as it stands after this byte
  assign flag_sel = flag_bits_next;
  assign info_sel = (phase == PH_INFO) ? in_byte : 8'd0;
  assign ch_ok    = {1'b0, flag_sel[4:0]} < num_channels;
  assign has_fx   = flag_sel[7] && (held_effect_byte_next != 8'hFF);
  assign emit     = emit_end || (emit_event && ch_ok);

  s3mped_fx_map u_fx_map (
    .effect_byte (held_effect_byte_next),
    .info        (info_sel),
    .fx          (fx)
  );

  // result outputs
  always_comb begin
    res_data = '0;
    if (!emit_end) begin
      res_data[5:0]   = row_count;
      res_data[10:6]  = flag_sel[4:0];
      res_data[11]    = flag_sel[5];
      res_data[19:12] = flag_sel[5] ? held_note_next : 8'hFF;
      res_data[27:20] = flag_sel[5] ? held_instrument_next : 8'd0;
      res_data[35:28] = flag_sel[6] ? held_volume_next : 8'hFF;
      res_data[36]    = has_fx;
      res_data[40:37] = has_fx ? fx.cmd : CMD_NONE;
      res_data[48:41] = has_fx ? fx.arg : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= res_data;
      m_tuser <= emit_end;
    end
  end

endmodule

>>> tb/s3m_pattern_event_decoder_top_test.sv
module s3m_pattern_event_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import s3mped_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 6;

  // effect letters of the packed stream
  localparam logic [7:0] FX_A    = 8'd1;
  localparam logic [7:0] FX_B    = 8'd2;
  localparam logic [7:0] FX_C    = 8'd3;
  localparam logic [7:0] FX_D    = 8'd4;
  localparam logic [7:0] FX_E    = 8'd5;
  localparam logic [7:0] FX_F    = 8'd6;
  localparam logic [7:0] FX_G    = 8'd7;
  localparam logic [7:0] FX_H    = 8'd8;
  localparam logic [7:0] FX_J    = 8'd10;
  localparam logic [7:0] FX_K    = 8'd11;
  localparam logic [7:0] FX_L    = 8'd12;
  localparam logic [7:0] FX_O    = 8'd15;
  localparam logic [7:0] FX_S    = 8'd19;
  localparam logic [7:0] FX_T    = 8'd20;
  localparam logic [7:0] FX_NONE = 8'hFF;

  typedef struct packed {
    logic       pat_end;
    logic [5:0] row;
    logic [4:0] chan;
    logic       has_note;
    logic [7:0] note;
    logic [7:0] instr;
    logic [7:0] vol;
    logic       has_fx;
    cmd_t       fx_cmd;
    logic [7:0] fx_arg;
  } row_event_t;

  class event_scoreboard;
    phase_t     phase;
    logic [5:0] row_cnt;
    logic [7:0] flags;
    logic [7:0] note_q;
    logic [7:0] instr_q;
    logic [7:0] vol_q;
    logic [7:0] fx_letter;
    logic [5:0] chans;
    row_event_t due[$];
    int         errors;

    function new();
      phase     = PH_LEN0;
      row_cnt   = '0;
      flags     = '0;
      note_q    = '0;
      instr_q   = '0;
      vol_q     = '0;
      fx_letter = '0;
      chans     = 6'd32;
      errors    = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function phase_t phase_after(phase_t done);
      if (done == PH_FLAG && flags[5]) return PH_NOTE;
      if (done != PH_VOL && flags[6]) return PH_VOL;
      if (flags[7]) return PH_CMD;
      return PH_FLAG;
    endfunction

    function void map_fx(logic [7:0] letter, logic [7:0] info, output cmd_t c,
                         output logic [7:0] a);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = info[7:4];
      lo = info[3:0];
      c = CMD_NONE;
      a = 8'h00;
      case (letter)
        FX_A, FX_T: begin c = CMD_SPEED; a = info; end
        FX_B: begin c = CMD_FASTSKIP; a = info; end
        FX_C: begin c = CMD_SKIP; a = info; end
        FX_D: begin
          if (lo == 4'h0 || hi == 4'h0) begin
            c = CMD_SLIDEVOL;
            a = info;
          end else if (hi == 4'hF) begin
            c = CMD_EXTENDED;
            a = 8'hB0 + lo;
          end else if (lo == 4'hF) begin
            c = CMD_EXTENDED;
            a = 8'hA0 + hi;
          end
        end
        FX_E: begin
          if (hi == 4'hF) begin
            c = CMD_EXTENDED;
            a = 8'h20 + lo;
          end else if (hi != 4'hE) begin
            c = CMD_UPSLIDE;
            a = info;
          end
        end
        FX_F: begin
          if (hi == 4'hF) begin
            c = CMD_EXTENDED;
            a = 8'h10 + lo;
          end else if (hi != 4'hE) begin
            c = CMD_DOWNSLIDE;
            a = info;
          end
        end
        FX_G: begin c = CMD_PORTA; a = info; end
        FX_H: begin c = CMD_VIBRATO; a = info; end
        FX_J: begin c = CMD_ARPEGGIO; a = info; end
        FX_K: begin c = CMD_VIBSLIDE; a = info; end
        FX_L: begin c = CMD_PORTASLIDE; a = info; end
        FX_O: begin c = CMD_OFFSET; a = info; end
        FX_S: begin
          case (hi)
            4'h2: a = 8'h50;
            4'h3: a = 8'h40;
            4'h4: a = 8'h70;
            4'hB: a = 8'h60;
            4'hC: a = 8'hC0;
            4'hD: a = 8'hD0;
            4'hE: a = 8'hE0;
            default: a = 8'h00;
          endcase
          // unsupported sub-effects leave both zero
          if (a != 8'h00) begin
            c = CMD_EXTENDED;
            a = a + lo;
          end
        end
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] info);
      row_event_t ev;
      if ({1'b0, flags[4:0]} >= chans) return;
      ev = '0;
      ev.row      = row_cnt;
      ev.chan     = flags[4:0];
      ev.has_note = flags[5];
      ev.note     = flags[5] ? note_q : 8'hFF;
      ev.instr    = flags[5] ? instr_q : 8'h00;
      ev.vol      = flags[6] ? vol_q : 8'hFF;
      ev.has_fx   = flags[7] && (fx_letter != FX_NONE);
      if (ev.has_fx) map_fx(fx_letter, info, ev.fx_cmd, ev.fx_arg);
      due.push_back(ev);
    endfunction

    function void take_byte(logic [7:0] b);
      row_event_t ev;
      int unsigned pitch;
      case (phase)
        PH_LEN0: phase = PH_LEN1;
        PH_LEN1: phase = PH_FLAG;
        PH_FLAG: begin
          if (b == 8'h00) begin
            if (int'(row_cnt) + 1 >= RowsPerPattern) begin
              row_cnt = '0;
              phase = PH_LEN0;
              ev = '0;
              ev.pat_end = 1'b1;
              due.push_back(ev);
            end else begin
              row_cnt = row_cnt + 6'd1;
            end
          end else begin
            flags = b;
            phase = phase_after(PH_FLAG);
            if (phase == PH_FLAG) emit(8'h00);
          end
        end
        PH_NOTE: begin
          pitch = b[7:4] * 12 + b[3:0];
          note_q = (pitch >= NoteLimit) ? 8'hFF : pitch[7:0];
          phase = PH_INSTR;
        end
        PH_INSTR: begin
          instr_q = b;
          phase = phase_after(PH_INSTR);
          if (phase == PH_FLAG) emit(8'h00);
        end
        PH_VOL: begin
          vol_q = ((b > 8'h40) ? 8'h40 : b) + 8'h10;
          phase = phase_after(PH_VOL);
          if (phase == PH_FLAG) emit(8'h00);
        end
        PH_CMD: begin
          fx_letter = b;
          phase = PH_INFO;
        end
        default: begin
          phase = PH_FLAG;
          emit(b);
        end
      endcase
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic user);
      row_event_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got tuser %0b tdata %h",
                 $time, user, data);
        return;
      end
      want = due.pop_front();
      cmp("is_pattern_end", want.pat_end, user);
      cmp("row", want.row, data[5:0]);
      cmp("channel", want.chan, data[10:6]);
      cmp("has_note", want.has_note, data[11]);
      cmp("note", want.note, data[19:12]);
      cmp("instrument", want.instr, data[27:20]);
      cmp("volume", want.vol, data[35:28]);
      cmp("has_effect", want.has_fx, data[36]);
      cmp("effect_cmd", want.fx_cmd, data[40:37]);
      cmp("effect_arg", want.fx_arg, data[48:41]);
      cmp("tdata padding", '0, data[OutDataW-1:49]);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [5:0]          cfg_data;

  event_scoreboard sb = new();

  int idle_pct;
  int sink_hold;
  int bytes_out;
  int rows_sent;
  int cycle_count;

  // first row of the first pattern: field extremes and a few effect corners
  logic [7:0] opening[$] = '{
    8'h00, 8'hFF,
    8'h1F,
    8'h20, 8'h00, 8'h00,
    8'h21, 8'h80, 8'hFF,
    8'hE2, 8'h7B, 8'h01, 8'h40, FX_D, 8'hF3,
    8'h43, 8'h41,
    8'h84, FX_NONE, 8'h55,
    8'h85, 8'h00, 8'h00,
    8'h00
  };

  s3m_pattern_event_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_note();
    if ($urandom_range(0, 9) < 7) return {4'($urandom_range(0, 7)), 4'($urandom_range(0, 11))};
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return FX_NONE;
    if (r < 20) return 8'($urandom);
    return 8'($urandom_range(0, 21));
  endfunction

  function automatic logic [7:0] pick_info();
    logic [3:0] hi;
    logic [3:0] lo;
    int r;
    r = $urandom_range(0, 99);
    hi = (r < 30) ? 4'hF : (r < 45) ? 4'hE : (r < 60) ? 4'h0 : 4'($urandom);
    r = $urandom_range(0, 99);
    lo = (r < 20) ? 4'hF : (r < 40) ? 4'h0 : 4'($urandom);
    return {hi, lo};
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_byte(b);
    bytes_out++;
  endtask

  task automatic send_entry();
    logic [7:0] flag;
    // now and then a stray byte that breaks the row layout
    if ($urandom_range(0, 49) == 0) begin
      send_byte(8'($urandom));
      return;
    end
    flag = 8'($urandom_range(1, 255));
    send_byte(flag);
    if (flag[5]) begin
      send_byte(pick_note());
      send_byte(8'($urandom));
    end
    if (flag[6]) begin
      send_byte(($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 64)) : 8'($urandom));
    end
    if (flag[7]) begin
      send_byte(pick_letter());
      send_byte(pick_info());
    end
  endtask

  task automatic send_row();
    int r;
    int n;
    if (rows_sent == 0) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 85) ? 1 : $urandom_range(2, 3);
    repeat (n) send_entry();
    send_byte(8'h00);
    rows_sent = (rows_sent + 1) % RowsPerPattern;
  endtask

  task automatic set_channels(logic [5:0] n);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.chans = n;
  endtask

  // source goes quiet until every expected result is out
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_phase(logic [5:0] chans, int idle, int hold, int budget);
    int start;
    set_channels(chans);
    idle_pct  = idle;
    sink_hold = hold;
    start = bytes_out;
    while (bytes_out - start < budget) send_row();
    finish_phase();
  endtask

  initial begin : sink
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** s3m_pattern_event_decoder_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    idle_pct  = 0;
    sink_hold = 0;
    bytes_out = 0;
    rows_sent = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 6'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_channels(6'd32);
    idle_pct = 20;
    foreach (opening[i]) send_byte(opening[i]);
    rows_sent = 1;
    finish_phase();

    // long sink hold with a busy source backs the block up
    run_phase(6'd63, 0, 300, 120);
    run_phase(6'd0, 25, 0, 50);
    run_phase(6'($urandom_range(2, 31)), 25, 0, 100);
    run_phase(6'd1, 10, 0, 40);
    run_phase(6'd33, 0, 0, 60);
    run_phase(6'($urandom_range(0, 63)), 35, 0, 80);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** s3m_pattern_event_decoder_top: PASSED **");
    end else begin
      $display("** s3m_pattern_event_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
